### src/hbs_pkg.sv
// Shared types and constants of the heightmap bilinear sampler.
// No dependencies; used by the top level, hbs_axis and the testbench.
package hbs_pkg;

    localparam int DEFAULT_GRID_WIDTH = 256;
    localparam int DEFAULT_GRID_DEPTH = 256;

    localparam int POS_W  = 24;
    localparam int INV_W  = 16;
    localparam int HGT_W  = 16;
    localparam int FRAC_W = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [INV_W-1:0] INV_CELL_SIZE_RESET = 16'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X      = 2'd0,
        CFG_ORIGIN_Z      = 2'd1,
        CFG_INV_CELL_SIZE = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_QUERY = 1'b1
    } t_req;

    typedef struct packed {
        logic sub_en;
        logic mul_en;
    } t_axis_ctl;

endpackage

### src/heightmap_bilinear_sampler.sv
// Top level of the heightmap bilinear sampler: control sequencer, blend
// datapath, configuration registers. Uses hbs_pkg, hbs_ram, hbs_axis.
//
// Usage: an item is transferred at a rising edge with start high and busy
// low. A write item (req_type 0) stores new_height at (cell_x, cell_z);
// writes outside the grid are dropped. A query item (req_type 1) maps
// query_x/query_z through origin and reciprocal cell size and returns the
// bilinear blend of the four neighbouring heights, with out_of_grid set
// when the position lies outside the grid, so an index was clamped to the edge.
// Every item gives one result: o_strobe is high for exactly one cycle
// with o_height_out and o_out_of_grid; the receiver cannot stall.
// Timing: a write result follows the S_WRITE state, a query result follows
// S_SUB, S_MUL, S_WGT, S_READ and S_FIN. busy drops in the strobe cycle, so
// a new item is taken only once the last result is out. The query time is set by
// the single read port of the height memory: four corner reads, one per
// cycle, through a registered multiply and accumulate.
// Configuration: i_cfg_valid/o_cfg_ready transfer with index and data;
// registers are to be written only while idle; the block itself does not
// enforce this. Reset (synchronous, active low) restores the register defaults
// and idles the sequencer; heights are undefined until written, so the memory is not cleared.
module heightmap_bilinear_sampler #(
    parameter int GRID_WIDTH = hbs_pkg::DEFAULT_GRID_WIDTH,
    parameter int GRID_DEPTH = hbs_pkg::DEFAULT_GRID_DEPTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_req_type,
    input  logic [7:0]                           i_cell_x,
    input  logic [7:0]                           i_cell_z,
    input  logic signed [hbs_pkg::HGT_W-1:0]     i_new_height,
    input  logic signed [hbs_pkg::POS_W-1:0]     i_query_x,
    input  logic signed [hbs_pkg::POS_W-1:0]     i_query_z,
    output logic                                 o_strobe,
    output logic signed [hbs_pkg::HGT_W-1:0]     o_height_out,
    output logic                                 o_out_of_grid,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [hbs_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [hbs_pkg::POS_W-1:0]            i_cfg_data
);

    localparam int XW = $clog2(GRID_WIDTH);
    localparam int ZW = $clog2(GRID_DEPTH);
    localparam int AW = $clog2(GRID_WIDTH * GRID_DEPTH);
    localparam int HW = hbs_pkg::HGT_W;
    localparam int WW = 17;
    localparam int SW = 34;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_WRITE = 7'b0000010,
        S_SUB   = 7'b0000100,
        S_MUL   = 7'b0001000,
        S_WGT   = 7'b0010000,
        S_READ  = 7'b0100000,
        S_FIN   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [2:0] r_cnt, n_cnt;

    logic signed [hbs_pkg::POS_W-1:0] r_origin_x, r_origin_z;
    logic [hbs_pkg::INV_W-1:0]        r_inv;

    logic                              r_req_type;
    logic [7:0]                        r_cell_x, r_cell_z;
    logic signed [HW-1:0]              r_new_height;
    logic signed [hbs_pkg::POS_W-1:0]  r_qx, r_qz;

    hbs_pkg::t_axis_ctl w_ctl;
    logic [XW-1:0] w_x0, w_x1;
    logic [ZW-1:0] w_z0, w_z1;
    logic [hbs_pkg::FRAC_W-1:0] w_fx, w_fz;
    logic w_oob_x, w_oob_z;
    logic [8:0] w_gx, w_gz;

    logic [WW-1:0] r_w [4];
    logic [AW-1:0] r_row0, r_row1;
    logic [ZW-1:0] r_z0, r_z1;
    logic          r_flag;

    logic          w_accept;
    logic          w_issue;
    logic          w_wr_in_grid;
    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [HW-1:0] w_rdata;
    logic [1:0]    r_cd;
    logic          r_dv, r_pv;
    logic signed [SW-1:0] r_prod, r_acc, w_rounded;
    logic signed [WW:0]   w_wsel;

    logic                 r_strobe;
    logic signed [HW-1:0] r_height_out;
    logic                 r_out_of_grid;

    assign w_accept    = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_z <= '0;
            r_inv      <= hbs_pkg::INV_CELL_SIZE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (hbs_pkg::t_cfg_idx'(i_cfg_index))
                hbs_pkg::CFG_ORIGIN_X:      r_origin_x <= $signed(i_cfg_data);
                hbs_pkg::CFG_ORIGIN_Z:      r_origin_z <= $signed(i_cfg_data);
                hbs_pkg::CFG_INV_CELL_SIZE: r_inv <= i_cfg_data[hbs_pkg::INV_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req_type   <= i_req_type;
            r_cell_x     <= i_cell_x;
            r_cell_z     <= i_cell_z;
            r_new_height <= i_new_height;
            r_qx         <= i_query_x;
            r_qz         <= i_query_z;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (hbs_pkg::t_req'(i_req_type) == hbs_pkg::REQ_WRITE) ?
                              S_WRITE : S_SUB;
                end
            end
            S_WRITE: n_state = S_IDLE;
            S_SUB:   n_state = S_MUL;
            S_MUL:   n_state = S_WGT;
            S_WGT: begin
                n_state = S_READ;
                n_cnt   = '0;
            end
            S_READ: begin
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd5) begin
                    n_state = S_FIN;
                end
            end
            S_FIN:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // coordinate mapping
    assign w_ctl.sub_en = (r_state == S_SUB);
    assign w_ctl.mul_en = (r_state == S_MUL);

    hbs_axis #(.SIZE(GRID_WIDTH)) u_axis_x (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_pos  (r_qx),
        .i_org  (r_origin_x),
        .i_inv  (r_inv),
        .o_idx0 (w_x0),
        .o_idx1 (w_x1),
        .o_frac (w_fx),
        .o_oob  (w_oob_x)
    );

    hbs_axis #(.SIZE(GRID_DEPTH)) u_axis_z (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_pos  (r_qz),
        .i_org  (r_origin_z),
        .i_inv  (r_inv),
        .o_idx0 (w_z0),
        .o_idx1 (w_z1),
        .o_frac (w_fz),
        .o_oob  (w_oob_z)
    );

    assign w_gx = 9'd256 - {1'b0, w_fx};
    assign w_gz = 9'd256 - {1'b0, w_fz};

    // corner order: (x0,z0) (x1,z0) (x0,z1) (x1,z1)
    always_ff @(posedge i_clk) begin
        if (r_state == S_WGT) begin
            r_w[0] <= {8'd0, w_gx} * {8'd0, w_gz};
            r_w[1] <= {8'd0, {1'b0, w_fx}} * {8'd0, w_gz};
            r_w[2] <= {8'd0, w_gx} * {8'd0, {1'b0, w_fz}};
            r_w[3] <= {8'd0, {1'b0, w_fx}} * {8'd0, {1'b0, w_fz}};
            r_row0 <= AW'(32'(w_x0) * GRID_DEPTH);
            r_row1 <= AW'(32'(w_x1) * GRID_DEPTH);
            r_z0   <= w_z0;
            r_z1   <= w_z1;
            r_flag <= w_oob_x || w_oob_z;
        end
    end

    // height memory
    assign w_wr_in_grid = (32'(r_cell_x) < GRID_WIDTH) && (32'(r_cell_z) < GRID_DEPTH);
    assign w_we    = (r_state == S_WRITE) && w_wr_in_grid;
    assign w_waddr = AW'(32'(r_cell_x) * GRID_DEPTH + 32'(r_cell_z));
    assign w_issue = (r_state == S_READ) && !r_cnt[2];
    assign w_raddr = (r_cnt[0] ? r_row1 : r_row0) + AW'(r_cnt[1] ? r_z1 : r_z0);

    hbs_ram #(.WIDTH(HW), .DEPTH(GRID_WIDTH * GRID_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_new_height),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // multiply-accumulate over the four corners
    assign w_wsel = $signed({1'b0, r_w[r_cd]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= 1'b0;
            r_pv <= 1'b0;
        end else begin
            r_dv <= w_issue;
            r_pv <= r_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cd <= r_cnt[1:0];
        if (r_dv) begin
            r_prod <= $signed(w_rdata) * w_wsel;
        end
        if (r_state == S_WGT) begin
            r_acc <= '0;
        end else if (r_pv) begin
            r_acc <= r_acc + r_prod;
        end
    end

    assign w_rounded = r_acc + SW'(32768);

    // result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (r_state == S_WRITE) || (r_state == S_FIN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE) begin
            r_height_out  <= '0;
            r_out_of_grid <= 1'b0;
        end else if (r_state == S_FIN) begin
            r_height_out  <= w_rounded[31:16];
            r_out_of_grid <= r_flag;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_height_out  = r_height_out;
    assign o_out_of_grid = r_out_of_grid;

    a_strobe_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while sequencer busy");

    a_read_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ && r_cnt == 3'd5) |=> (r_state == S_FIN && !r_dv))
        else $error("corner reads not drained at end of query");

    a_write_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && hbs_pkg::t_req'(r_req_type) == hbs_pkg::REQ_WRITE) |->
        (o_height_out == '0 && !o_out_of_grid))
        else $error("write transfer returned nonzero result");

endmodule

### src/hbs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module hbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/hbs_axis.sv
// One axis of the position-to-cell mapping: origin subtract, reciprocal
// multiply, floor to cell index with fraction, edge clamp. Uses hbs_pkg.
module hbs_axis #(
    parameter int SIZE = hbs_pkg::DEFAULT_GRID_WIDTH
) (
    input  logic                              i_clk,
    input  hbs_pkg::t_axis_ctl                i_ctl,
    input  logic signed [hbs_pkg::POS_W-1:0]  i_pos,
    input  logic signed [hbs_pkg::POS_W-1:0]  i_org,
    input  logic [hbs_pkg::INV_W-1:0]         i_inv,
    output logic [$clog2(SIZE)-1:0]           o_idx0,
    output logic [$clog2(SIZE)-1:0]           o_idx1,
    output logic [hbs_pkg::FRAC_W-1:0]        o_frac,
    output logic                              o_oob
);

    localparam int IW   = $clog2(SIZE);
    localparam int DW   = hbs_pkg::POS_W + 1;
    localparam int PW   = DW + hbs_pkg::INV_W + 1;
    localparam int CW   = PW - 16;
    localparam int EW   = CW + 1;
    localparam logic signed [EW-1:0] LAST = EW'(SIZE - 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(SIZE - 1);

    logic signed [DW-1:0] r_diff;
    logic signed [PW-1:0] r_prod;
    logic signed [hbs_pkg::INV_W:0] w_inv_s;
    logic signed [PW-1:0] w_prod;
    logic signed [EW-1:0] w_cell0;
    logic signed [EW-1:0] w_cell1;

    assign w_inv_s = $signed({1'b0, i_inv});
    assign w_prod  = r_diff * w_inv_s;

    always_ff @(posedge i_clk) begin
        if (i_ctl.sub_en) begin
            r_diff <= {i_pos[hbs_pkg::POS_W-1], i_pos} - {i_org[hbs_pkg::POS_W-1], i_org};
        end
        if (i_ctl.mul_en) begin
            r_prod <= w_prod;
        end
    end

    // floor: arithmetic view of the top bits
    assign w_cell0 = {r_prod[PW-1], r_prod[PW-1:16]};
    assign w_cell1 = w_cell0 + EW'(1);
    assign o_frac  = r_prod[15:8];

    assign o_idx0 = (w_cell0 < 0) ? '0 : ((w_cell0 > LAST) ? LAST_IDX : w_cell0[IW-1:0]);
    assign o_idx1 = (w_cell1 < 0) ? '0 : ((w_cell1 > LAST) ? LAST_IDX : w_cell1[IW-1:0]);
    assign o_oob  = (w_cell0 < 0) || (w_cell0 > LAST) || ((w_cell0 == LAST) && (o_frac != '0));

endmodule

### tb/heightmap_bilinear_sampler_checker.sv
// Scoreboard for the heightmap bilinear sampler: watches the item, result and
// register channels, keeps its own height grid and register copy, and checks
// each result in order. Depends on hbs_pkg.
module heightmap_bilinear_sampler_checker
    import hbs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic                    i_busy,
    input  logic                    i_req_type,
    input  logic [7:0]              i_cell_x,
    input  logic [7:0]              i_cell_z,
    input  logic signed [HGT_W-1:0] i_new_height,
    input  logic signed [POS_W-1:0] i_query_x,
    input  logic signed [POS_W-1:0] i_query_z,
    input  logic                    i_strobe,
    input  logic signed [HGT_W-1:0] i_height_out,
    input  logic                    i_out_of_grid,
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [POS_W-1:0]        i_cfg_data,
    output int                      o_errors,
    output int                      o_pending,
    output int                      o_results,
    output int                      o_clamped
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_W = DEFAULT_GRID_WIDTH;
    localparam int GRID_D = DEFAULT_GRID_DEPTH;

    typedef struct packed {
        logic signed [HGT_W-1:0] height;
        logic                    clamped;
    } t_sample;

    logic signed [HGT_W-1:0] heights [GRID_W*GRID_D];
    logic signed [POS_W-1:0] org_x, org_z;
    logic [INV_W-1:0]        inv_step;
    t_sample                 awaited_samples [$];
    int err_count    = 0;
    int result_count = 0;
    int clamp_count  = 0;
    int pending_n    = 0;

    assign o_errors  = err_count;
    assign o_pending = pending_n;
    assign o_results = result_count;
    assign o_clamped = clamp_count;

    task automatic report(string what, longint got, longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        err_count++;
    endtask

    task automatic enqueue(t_sample s);
        awaited_samples = {awaited_samples, s};
    endtask

    // floored cell index and 8-bit fraction of one axis
    function automatic void locate(input logic signed [POS_W-1:0] pos, org,
                                   output longint cidx, output int frac);
        longint p;
        p    = (longint'(pos) - longint'(org)) * longint'(inv_step);
        cidx = p >>> 16;
        frac = int'(p[15:8]);
    endfunction

    function automatic bit beyond(longint cidx, int frac, int size);
        return cidx < 0 || cidx > size - 1 || (cidx == size - 1 && frac != 0);
    endfunction

    function automatic int clamp_index(longint v, int hi);
        if (v < 0) return 0;
        if (v > hi) return hi;
        return int'(v);
    endfunction

    function automatic t_sample blend_height(logic signed [POS_W-1:0] qx, qz);
        longint  cx, cz, acc, gx, gz;
        int      fx, fz, x0, x1, z0, z1;
        t_sample s;
        locate(qx, org_x, cx, fx);
        locate(qz, org_z, cz, fz);
        s.clamped = beyond(cx, fx, GRID_W) || beyond(cz, fz, GRID_D);
        x0 = clamp_index(cx, GRID_W - 1);
        x1 = clamp_index(cx + 1, GRID_W - 1);
        z0 = clamp_index(cz, GRID_D - 1);
        z1 = clamp_index(cz + 1, GRID_D - 1);
        gx = 256 - fx;
        gz = 256 - fz;
        acc = longint'(heights[x0*GRID_D + z0]) * gx * gz
            + longint'(heights[x1*GRID_D + z0]) * fx * gz
            + longint'(heights[x0*GRID_D + z1]) * gx * fz
            + longint'(heights[x1*GRID_D + z1]) * fx * fz;
        acc = (acc + 32768) >>> 16;
        s.height = HGT_W'(acc);
        return s;
    endfunction

    always @(posedge i_clk) begin : watch
        t_sample want;
        if (!i_rst_n) begin
            org_x    = '0;
            org_z    = '0;
            inv_step = INV_CELL_SIZE_RESET;
        end else begin
            if (i_strobe) begin
                result_count++;
                if (i_out_of_grid === 1'b1) clamp_count++;
                if (awaited_samples.size() == 0) begin
                    report("unexpected result, height_out", i_height_out, 0);
                end else begin
                    want = awaited_samples.pop_front();
                    if (i_height_out !== want.height)
                        report("height_out", i_height_out, want.height);
                    if (i_out_of_grid !== want.clamped)
                        report("out_of_grid", i_out_of_grid, want.clamped);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ORIGIN_X:      org_x    = i_cfg_data;
                    CFG_ORIGIN_Z:      org_z    = i_cfg_data;
                    CFG_INV_CELL_SIZE: inv_step = i_cfg_data[INV_W-1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                if (i_req_type == REQ_WRITE) begin
                    if (int'(i_cell_x) < GRID_W && int'(i_cell_z) < GRID_D)
                        heights[int'(i_cell_x)*GRID_D + int'(i_cell_z)] = i_new_height;
                    enqueue('0);
                end else begin
                    enqueue(blend_height(i_query_x, i_query_z));
                end
            end
        end
        pending_n <= awaited_samples.size();
    end

endmodule

### tb/heightmap_bilinear_sampler_test.sv
// Top of the heightmap bilinear sampler testbench: clock, reset, register
// set-up and item stimulus; checking is done by the scoreboard module.
// Depends on hbs_pkg, heightmap_bilinear_sampler and its checker.
module heightmap_bilinear_sampler_test;
    timeunit 1ns;
    timeprecision 1ps;
    import hbs_pkg::*;

    localparam int GRID_W = DEFAULT_GRID_WIDTH;
    localparam int GRID_D = DEFAULT_GRID_DEPTH;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic signed [POS_W-1:0] POS_MIN = 24'sh800000;
    localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;

    logic                    i_clk        = 1'b0;
    logic                    i_rst_n      = 1'b0;
    logic                    start        = 1'b0;
    logic                    busy;
    logic                    i_req_type   = REQ_WRITE;
    logic [7:0]              i_cell_x     = '0;
    logic [7:0]              i_cell_z     = '0;
    logic signed [HGT_W-1:0] i_new_height = '0;
    logic signed [POS_W-1:0] i_query_x    = '0;
    logic signed [POS_W-1:0] i_query_z    = '0;
    logic                    o_strobe;
    logic signed [HGT_W-1:0] o_height_out;
    logic                    o_out_of_grid;
    logic                    i_cfg_valid  = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index  = '0;
    logic [POS_W-1:0]        i_cfg_data   = '0;

    int errors, pending, results, clamped;

    bit                      filled [GRID_W*GRID_D];
    logic signed [POS_W-1:0] cur_org_x = '0;
    logic signed [POS_W-1:0] cur_org_z = '0;
    logic [INV_W-1:0]        cur_inv   = INV_CELL_SIZE_RESET;
    int n_items = 0, n_writes = 0, n_queries = 0, n_regs = 0, burst_left = 0;

    heightmap_bilinear_sampler dut (.*);

    heightmap_bilinear_sampler_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req_type   (i_req_type),
        .i_cell_x     (i_cell_x),
        .i_cell_z     (i_cell_z),
        .i_new_height (i_new_height),
        .i_query_x    (i_query_x),
        .i_query_z    (i_query_z),
        .i_strobe     (o_strobe),
        .i_height_out (o_height_out),
        .i_out_of_grid(o_out_of_grid),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_results    (results),
        .o_clamped    (clamped)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // start stays high across back-to-back items; lowered only ahead of a gap
    task automatic send(t_req kind, logic [7:0] cx, cz, logic signed [HGT_W-1:0] h,
                        logic signed [POS_W-1:0] qx, qz);
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 9) == 0) burst_left = $urandom_range(8, 40);
            gap = $urandom_range(0, 16);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_type   <= kind;
        i_cell_x     <= cx;
        i_cell_z     <= cz;
        i_new_height <= h;
        i_query_x    <= qx;
        i_query_z    <= qz;
        start        <= 1'b1;
        do @(posedge i_clk); while (busy);
        n_items++;
    endtask

    task automatic put_height(logic [7:0] cx, cz, logic signed [HGT_W-1:0] h);
        send(REQ_WRITE, cx, cz, h, POS_W'($urandom), POS_W'($urandom));
        filled[int'(cx)*GRID_D + int'(cz)] = 1'b1;
        n_writes++;
    endtask

    function automatic longint cell_of(logic signed [POS_W-1:0] pos, org);
        return ((longint'(pos) - longint'(org)) * longint'(cur_inv)) >>> 16;
    endfunction

    function automatic int edge_clamp(longint v, int hi);
        if (v < 0) return 0;
        if (v > hi) return hi;
        return int'(v);
    endfunction

    // unwritten corners are filled first so no query reads an empty cell
    task automatic ask(logic signed [POS_W-1:0] qx, qz);
        longint cx, cz;
        int     xs [2];
        int     zs [2];
        int     a, b;
        cx = cell_of(qx, cur_org_x);
        cz = cell_of(qz, cur_org_z);
        xs[0] = edge_clamp(cx, GRID_W - 1);
        xs[1] = edge_clamp(cx + 1, GRID_W - 1);
        zs[0] = edge_clamp(cz, GRID_D - 1);
        zs[1] = edge_clamp(cz + 1, GRID_D - 1);
        for (a = 0; a < 2; a++)
            for (b = 0; b < 2; b++)
                if (!filled[xs[a]*GRID_D + zs[b]])
                    put_height(8'(xs[a]), 8'(zs[b]), HGT_W'($urandom));
        send(REQ_QUERY, 8'($urandom), 8'($urandom), HGT_W'($urandom), qx, qz);
        n_queries++;
    endtask

    // world position landing on a chosen cell with a random fraction
    function automatic logic signed [POS_W-1:0] aim(int cidx, logic signed [POS_W-1:0] org);
        longint t, off;
        t = longint'(cidx) * 65536 + longint'($urandom_range(0, 65535));
        if (cur_inv == 0) off = longint'($urandom_range(0, 1023));
        else off = t / longint'(cur_inv);
        return POS_W'(longint'(org) + off);
    endfunction

    function automatic int edge_cell();
        int k;
        k = $urandom_range(0, 7);
        return k < 4 ? k - 2 : GRID_W + k - 6;
    endfunction

    task automatic settle();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [POS_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        n_regs++;
    endtask

    task automatic set_config(logic signed [POS_W-1:0] ox, oz, logic [POS_W-1:0] inv_word,
                              bit spare);
        settle();
        reg_write(CFG_ORIGIN_X, ox);
        reg_write(CFG_ORIGIN_Z, oz);
        if (spare) reg_write(CFG_SPARE, POS_W'($urandom));
        reg_write(CFG_INV_CELL_SIZE, inv_word);
        i_cfg_valid <= 1'b0;
        cur_org_x = ox;
        cur_org_z = oz;
        cur_inv   = inv_word[INV_W-1:0];
    endtask

    function automatic logic signed [POS_W-1:0] rand_origin();
        if ($urandom_range(0, 1) == 0) return POS_W'($urandom);
        return POS_W'(int'($urandom_range(0, 8191)) - 4096);
    endfunction

    function automatic logic [POS_W-1:0] rand_inv();
        logic [INV_W-1:0] v;
        case ($urandom_range(0, 3))
            0:       v = 16'd1;
            1:       v = 16'hFFFF;
            2:       v = 16'($urandom_range(1, 65535));
            default: v = 16'($urandom_range(128, 1024));
        endcase
        return {8'($urandom), v};
    endfunction

    task automatic rand_item(int win_x, int win_z);
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            ask(aim(win_x + $urandom_range(0, 15), cur_org_x),
                aim(win_z + $urandom_range(0, 15), cur_org_z));
        else if (r < 55)
            ask(aim(edge_cell(), cur_org_x), aim($urandom_range(0, 255), cur_org_z));
        else if (r < 65)
            ask(aim($urandom_range(0, 255), cur_org_x), aim(edge_cell(), cur_org_z));
        else if (r < 70)
            ask(aim(edge_cell(), cur_org_x), aim(edge_cell(), cur_org_z));
        else if (r < 80)
            ask(POS_W'($urandom), POS_W'($urandom));
        else if (r < 90)
            put_height(8'(win_x + $urandom_range(0, 15)), 8'(win_z + $urandom_range(0, 15)),
                       HGT_W'($urandom));
        else
            put_height(8'($urandom), 8'($urandom), HGT_W'($urandom));
    endtask

    initial begin
        int ph, win_x, win_z;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default registers: world unit per cell, origin at zero
        put_height(8'd0,   8'd0,   16'sh8000);
        put_height(8'd1,   8'd0,   16'sh7FFF);
        put_height(8'd0,   8'd1,   16'sh7FFF);
        put_height(8'd1,   8'd1,   16'sh8000);
        put_height(8'd255, 8'd255, 16'sh7FFF);
        put_height(8'd254, 8'd255, 16'sh8000);
        put_height(8'd255, 8'd254, -16'sd1);
        put_height(8'd254, 8'd254, 16'sh0000);
        put_height(8'd0,   8'd255, 16'sh5555);
        put_height(8'd255, 8'd0,   16'shAAAA);
        ask(24'sh000000, 24'sh000000);
        ask(24'sh000080, 24'sh000080);
        ask(24'sh000040, 24'sh0000C0);
        ask(24'sh00FF00, 24'sh00FF00);
        ask(24'sh00FF80, 24'sh00FF00);
        ask(-24'sd1,     24'sh000010);
        ask(POS_MIN,     POS_MIN);
        ask(POS_MAX,     POS_MAX);
        ask(24'sh00007F, 24'sh00FF00);
        ask(24'sh0000FF, 24'sh000001);

        for (ph = 0; ph < 10; ph++) begin
            case (ph)
                0:       set_config(POS_MIN, POS_MAX, 24'd1, 1'b1);
                1:       set_config(POS_MAX, POS_MIN, {8'($urandom), 16'hFFFF}, 1'b0);
                2:       set_config(rand_origin(), rand_origin(), {8'($urandom), 16'h0000}, 1'b0);
                3:       set_config('0, '0, {8'($urandom), 16'd256}, 1'b0);
                default: set_config(rand_origin(), rand_origin(), rand_inv(), ph == 5);
            endcase
            win_x = $urandom_range(0, GRID_W - 16);
            win_z = $urandom_range(0, GRID_D - 16);
            while (n_items < 20 + (ph + 1) * 118) begin
                rand_item(win_x, win_z);
                if ($urandom_range(0, 199) == 0) settle();
            end
        end

        settle();
        repeat (32) @(posedge i_clk);
        $display("Sent %0d height writes and %0d queries across %0d register transfers.",
                 n_writes, n_queries, n_regs);
        $display("Checked %0d results, %0d of them clamped to the grid edge.",
                 results, clamped);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Timed out with %0d results outstanding", pending);
        $display("Verification failed");
        $finish;
    end

endmodule
